// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker modules.
// Each expects signals named clk and arst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/pwd_pkg.sv =====
// Shared types and constants for the piecewise decompanding table.
// No dependencies; imported by every module of the block.
package pwd_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 40;
	localparam int LIMIT_W    = 13;
	localparam int CODE_W     = 8;
	localparam int OUT_W      = 13;
	localparam int SEG_LIMITS = 5;
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 16;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SEG_LIMIT_0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEG_LIMIT_1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEG_LIMIT_2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEG_LIMIT_3 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SEG_LIMIT_4 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SEG_OFFSETS = 3'd5;

	// Request kinds on tuser
	localparam logic KIND_REBUILD = 1'b0;
	localparam logic KIND_DECODE  = 1'b1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 13'd4096;
	localparam logic [CODE_W-1:0]  FIRST_OFFSET  = 8'(9999 % 256);
	localparam logic [OUT_W-1:0]   NO_CODE_VALUE = 13'd4999;

	typedef struct packed {
		logic start;    // clear code history, rewind value counter
		logic step;     // compand the next input value
		logic rd_en;    // look up the requested pixel code
		logic load_dec; // load decode result into output register
		logic flush;    // close the open run, post rebuild acknowledge
	} dp_cmd_t;

	typedef struct packed {
		logic last_value; // counter holds the last input value
		logic out_free;   // output register can take a result this cycle
	} dp_stat_t;

endpackage

// ===== hw/rtl/pwd_ctrl.sv =====
// Sequencer for table rebuilds and pixel lookups.
// Depends on pwd_pkg for the command and status structs.
module pwd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              kind,
	output logic              s_tready,
	input  pwd_pkg::dp_stat_t stat,
	output pwd_pkg::dp_cmd_t  cmd
);
	import pwd_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_SWEEP = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_FLUSH = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE) && stat.out_free;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd          = '0;
		cmd.start    = accept && (kind == KIND_REBUILD);
		cmd.rd_en    = accept && (kind == KIND_DECODE);
		cmd.step     = (state_q == ST_SWEEP);
		cmd.load_dec = (state_q == ST_READ);
		cmd.flush    = (state_q == ST_FLUSH);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (kind == KIND_DECODE) ? ST_READ : ST_SWEEP;
				end
			end
			ST_READ:  state_d = ST_IDLE;
			ST_SWEEP: begin
				if (stat.last_value) begin
					state_d = ST_DRAIN;
				end
			end
			// let the compand stage retire its last value
			ST_DRAIN: state_d = ST_FLUSH;
			ST_FLUSH: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/pwd_dp.sv =====
// Datapath: value counter, compand stage, run tracker, decode table memory
// and output register. Depends on pwd_pkg; driven by pwd_ctrl commands.
module pwd_dp #(
	parameter int CODE_ENTRIES = 256,
	parameter int INPUT_RANGE  = 4096
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  pwd_pkg::dp_cmd_t                                     cmd,
	output pwd_pkg::dp_stat_t                                    stat,
	input  logic [pwd_pkg::CODE_W-1:0]                           pixel_code,
	input  logic [pwd_pkg::SEG_LIMITS-1:0][pwd_pkg::LIMIT_W-1:0] seg_limit,
	input  logic [pwd_pkg::CFG_DATA_W-1:0]                       seg_offsets,
	input  logic                                                 out_ready,
	output logic                                                 out_valid,
	output logic [pwd_pkg::OUT_W-1:0]                            out_value,
	output logic                                                 out_done
);
	import pwd_pkg::*;

	localparam int VW   = $clog2(INPUT_RANGE);
	localparam int CW   = $clog2(CODE_ENTRIES);
	localparam int CMPW = (VW > LIMIT_W) ? VW : LIMIT_W;

	// value counter and compand stage
	logic [VW-1:0]     cnt_q;
	logic [2:0]        seg;
	logic [VW-1:0]     shifted;
	logic [CODE_W-1:0] offset;
	logic [CODE_W-1:0] code_c;

	logic              valid_s1;
	logic              first_s1;
	logic [VW-1:0]     v_s1;
	logic [CODE_W-1:0] code_s1;

	// run tracker
	logic [CODE_W-1:0] cur_code_q;
	logic [VW-1:0]     cur_first_q;
	logic [VW-1:0]     last_q;
	logic              cur_rec_q;
	logic [CODE_ENTRIES-1:0] seen_q;

	logic              new_run;
	logic              new_in_tab;
	logic              new_rec;
	logic              close_wr;
	logic [VW:0]       run_sum;
	logic [OUT_W-1:0]  mid;

	// lookup
	logic [OUT_W-1:0]  mem_q [CODE_ENTRIES];
	logic [OUT_W-1:0]  rd_s1;
	logic              hit_s1;
	logic              req_in_tab;

	logic              out_valid_q;
	logic [OUT_W-1:0]  out_value_q;
	logic              out_done_q;

	assign stat.last_value = (cnt_q == VW'(INPUT_RANGE - 1));
	assign stat.out_free   = !out_valid_q || out_ready;

	always_comb begin
		priority if (CMPW'(cnt_q) < CMPW'(seg_limit[0])) seg = 3'd0;
		else if (CMPW'(cnt_q) < CMPW'(seg_limit[1]))     seg = 3'd1;
		else if (CMPW'(cnt_q) < CMPW'(seg_limit[2]))     seg = 3'd2;
		else if (CMPW'(cnt_q) < CMPW'(seg_limit[3]))     seg = 3'd3;
		else if (CMPW'(cnt_q) < CMPW'(seg_limit[4]))     seg = 3'd4;
		else                                             seg = 3'd5;
	end

	always_comb begin
		unique case (seg)
			3'd0:    offset = FIRST_OFFSET;
			3'd1:    offset = seg_offsets[7:0];
			3'd2:    offset = seg_offsets[15:8];
			3'd3:    offset = seg_offsets[23:16];
			3'd4:    offset = seg_offsets[31:24];
			default: offset = seg_offsets[39:32];
		endcase
	end

	assign shifted = cnt_q >> seg;
	assign code_c  = shifted[CODE_W-1:0] + offset;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cmd.start) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			valid_s1 <= cmd.step;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			v_s1     <= cnt_q;
			code_s1  <= code_c;
			first_s1 <= (cnt_q == '0);
		end
	end

	// A code keeps only its first run: record a run only if the code was unseen
	assign new_run    = valid_s1 && (first_s1 || (code_s1 != cur_code_q));
	assign new_in_tab = ({1'b0, code_s1} < (CODE_W + 1)'(CODE_ENTRIES));
	assign new_rec    = new_in_tab && !seen_q[code_s1[CW-1:0]];
	assign close_wr   = cur_rec_q && ((new_run && !first_s1) || cmd.flush);
	assign run_sum    = {1'b0, cur_first_q} + {1'b0, last_q};
	assign mid        = OUT_W'(run_sum[VW:1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= '0;
			cur_rec_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				seen_q <= '0;
			end else if (new_run && new_rec) begin
				seen_q[code_s1[CW-1:0]] <= 1'b1;
			end
			if (new_run) begin
				cur_rec_q <= new_rec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			last_q <= v_s1;
		end
		if (new_run) begin
			cur_code_q  <= code_s1;
			cur_first_q <= v_s1;
		end
	end

	assign req_in_tab = ({1'b0, pixel_code} < (CODE_W + 1)'(CODE_ENTRIES));

	always_ff @(posedge clk) begin
		if (close_wr) begin
			mem_q[cur_code_q[CW-1:0]] <= mid;
		end
		if (cmd.rd_en) begin
			rd_s1 <= mem_q[pixel_code[CW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			hit_s1 <= req_in_tab && seen_q[pixel_code[CW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_dec || cmd.flush) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_dec) begin
			out_value_q <= hit_s1 ? rd_s1 : NO_CODE_VALUE;
			out_done_q  <= 1'b0;
		end else if (cmd.flush) begin
			out_value_q <= '0;
			out_done_q  <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_done  = out_done_q;

endmodule

// ===== hw/rtl/piecewise_decompand_table.sv =====
// Decode: the table read is registered, then loaded into the output register; a new request waits until that is done.
// Rebuild: one input value per cycle through the compand stage, acknowledge after the sweep
// and the drain and flush states; the decode table memory takes one run write per cycle.
// Reset clears the sequencer, code history and configuration (limits 4096, offsets 0);
// table contents are undefined until the first rebuild.
// Top level: configuration registers, sequencer and datapath.
module piecewise_decompand_table #(
	parameter int CODE_ENTRIES = 256,
	parameter int INPUT_RANGE  = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [pwd_pkg::IN_DATA_W-1:0]    s_tdata,  // [7:0] pixel_code
	input  logic                             s_tuser,  // [0] kind
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [pwd_pkg::OUT_DATA_W-1:0]   m_tdata,  // [12:0] decoded_value, [15:13] zero
	output logic                             m_tuser,  // [0] rebuild_done
	input  logic                             cfg_we,
	input  logic [pwd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pwd_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import pwd_pkg::*;

	logic [SEG_LIMITS-1:0][LIMIT_W-1:0] seg_limit_q;
	logic [CFG_DATA_W-1:0]              seg_offsets_q;
	dp_cmd_t                            cmd;
	dp_stat_t                           stat;
	logic [OUT_W-1:0]                   out_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_limit_q   <= {SEG_LIMITS{LIMIT_RESET}};
			seg_offsets_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SEG_LIMIT_0: seg_limit_q[0] <= cfg_data[LIMIT_W-1:0];
				REG_SEG_LIMIT_1: seg_limit_q[1] <= cfg_data[LIMIT_W-1:0];
				REG_SEG_LIMIT_2: seg_limit_q[2] <= cfg_data[LIMIT_W-1:0];
				REG_SEG_LIMIT_3: seg_limit_q[3] <= cfg_data[LIMIT_W-1:0];
				REG_SEG_LIMIT_4: seg_limit_q[4] <= cfg_data[LIMIT_W-1:0];
				REG_SEG_OFFSETS: seg_offsets_q  <= cfg_data;
				default: ; // drop writes to unused indexes
			endcase
		end
	end

	pwd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.kind     (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	pwd_dp #(
		.CODE_ENTRIES (CODE_ENTRIES),
		.INPUT_RANGE  (INPUT_RANGE)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.pixel_code  (s_tdata[CODE_W-1:0]),
		.seg_limit   (seg_limit_q),
		.seg_offsets (seg_offsets_q),
		.out_ready   (m_tready),
		.out_valid   (m_tvalid),
		.out_value   (out_value),
		.out_done    (m_tuser)
	);

	assign m_tdata = OUT_DATA_W'(out_value);

endmodule

// ===== hw/rtl/pwd_checker.sv =====
// Port-level checks for piecewise_decompand_table, attached by bind.
// Depends on pwd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pwd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [pwd_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                           m_tuser
);
	import pwd_pkg::*;

	`CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
	`CHK_IMPLY(a_no_take_when_full, m_tvalid && !m_tready, !s_tready, "request taken while result stalled")
	`CHK_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "request taken while busy")
	`CHK_IMPLY(a_ack_zero, m_tvalid && m_tuser, m_tdata == '0, "rebuild acknowledge carries data")
	`CHK_IMPLY(a_pad_zero, m_tvalid, m_tdata[OUT_DATA_W-1:OUT_W] == '0, "result padding not zero")

endmodule

bind piecewise_decompand_table pwd_checker u_pwd_checker (.*);

// ===== sim/piecewise_decompand_table_tb.sv =====
// Self-checking testbench for piecewise_decompand_table: table rebuilds and pixel decodes.
// Depends on pwd_pkg and the piecewise_decompand_table RTL; predicts every result in-line.
`timescale 1ns / 1ps

module piecewise_decompand_table_tb;
	import pwd_pkg::*;

	localparam int CODE_COUNT   = 256;
	localparam int VALUE_COUNT  = 4096;
	localparam int QUIET_LIMIT  = 20000;
	localparam int MAX_REPORTS  = 10;
	localparam int RAND_PHASES  = 8;
	localparam int LIMIT_MAX    = (1 << LIMIT_W) - 1;

	localparam logic [1:0] RUN_NONE   = 2'd0;
	localparam logic [1:0] RUN_OPEN   = 2'd1;
	localparam logic [1:0] RUN_CLOSED = 2'd2;

	typedef struct {
		logic             kind;
		logic [CODE_W-1:0] code;
	} pixel_req_t;

	typedef struct {
		logic [OUT_W-1:0] value;
		logic             done;
	} decode_answer_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;   // [7:0] pixel_code
	logic                  s_tuser = 1'b0; // [0] kind
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;        // [12:0] decoded_value, [15:13] zero
	logic                  m_tuser;        // [0] rebuild_done
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	pixel_req_t     pixel_requests [$];
	decode_answer_t decode_answers [$];

	// Configuration and table as the block should hold them
	logic [LIMIT_W-1:0]    lim_cfg [SEG_LIMITS];
	logic [CFG_DATA_W-1:0] offs_cfg;
	logic [OUT_W-1:0]      decode_lut [CODE_COUNT];

	logic [LIMIT_W-1:0]    next_lims [SEG_LIMITS];
	logic [CFG_DATA_W-1:0] next_offs;

	int  src_gap = 0;
	int  snk_wait = 0;
	bit  src_burst = 1'b0;
	bit  snk_burst = 1'b0;
	int  mismatches = 0;

	piecewise_decompand_table u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Compand every input value and keep the midpoint of each code's first run
	function automatic void rebuild_lut();
		logic [1:0]        status [CODE_COUNT];
		int                first_v [CODE_COUNT];
		int                last_v [CODE_COUNT];
		int                seg;
		logic [CODE_W-1:0] code;
		logic [CODE_W-1:0] prev;
		logic [CODE_W-1:0] offs;
		bit                have_prev;
		have_prev = 1'b0;
		prev = '0;
		for (int c = 0; c < CODE_COUNT; c++) begin
			status[c] = RUN_NONE;
			first_v[c] = 0;
			last_v[c] = 0;
		end
		for (int v = 0; v < VALUE_COUNT; v++) begin
			seg = SEG_LIMITS;
			// scan downward so the lowest matching segment wins
			for (int s = SEG_LIMITS - 1; s >= 0; s--) begin
				if (v < int'(lim_cfg[s]))
					seg = s;
			end
			offs = (seg == 0) ? FIRST_OFFSET : offs_cfg[8*(seg-1) +: 8];
			code = CODE_W'((v >> seg) + int'(offs));
			if (have_prev && prev != code && status[prev] == RUN_OPEN)
				status[prev] = RUN_CLOSED;
			if (status[code] == RUN_NONE) begin
				first_v[code] = v;
				last_v[code] = v;
				status[code] = RUN_OPEN;
			end else if (status[code] == RUN_OPEN) begin
				last_v[code] = v;
			end
			prev = code;
			have_prev = 1'b1;
		end
		for (int c = 0; c < CODE_COUNT; c++) begin
			if (status[c] != RUN_NONE)
				decode_lut[c] = OUT_W'((first_v[c] + last_v[c]) >> 1);
			else
				decode_lut[c] = NO_CODE_VALUE;
		end
	endfunction

	task automatic push_item(input logic kind, input logic [CODE_W-1:0] code);
		pixel_req_t req;
		req.kind = kind;
		req.code = code;
		pixel_requests.push_back(req);
	endtask

	task automatic wait_idle();
		while (pixel_requests.size() != 0 || s_tvalid || decode_answers.size() != 0)
			@(posedge clk);
	endtask

	// Write all six registers back to back; only called while the block is idle
	task automatic apply_config();
		for (int r = 0; r < SEG_LIMITS; r++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= REG_SEG_LIMIT_0 + CFG_IDX_W'(r);
			cfg_data <= CFG_DATA_W'(next_lims[r]);
			lim_cfg[r] = next_lims[r];
		end
		@(posedge clk);
		cfg_index <= REG_SEG_OFFSETS;
		cfg_data <= next_offs;
		offs_cfg = next_offs;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Source side: present requests from the queue with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
			src_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (s_tuser == KIND_REBUILD) begin
					rebuild_lut();
					decode_answers.push_back('{value: '0, done: 1'b1});
				end else begin
					decode_answers.push_back('{value: decode_lut[s_tdata[CODE_W-1:0]],
						done: 1'b0});
				end
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap != 0) begin
					src_gap <= src_gap - 1;
					s_tvalid <= 1'b0;
				end else if (pixel_requests.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tuser <= pixel_requests[0].kind;
					s_tdata <= IN_DATA_W'(pixel_requests[0].code);
					pixel_requests.delete(0);
					src_gap <= src_burst ? 0 : int'($urandom_range(0, 7));
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Sink side: stall at random, compare each result with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : result_check
		decode_answer_t ans;
		int             draw;
		if (!arst_n) begin
			m_tready <= 1'b0;
			snk_wait <= 0;
		end else if (m_tvalid && m_tready) begin
			if (decode_answers.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < MAX_REPORTS)
					$display("unexpected result: tdata=%h tuser=%b", m_tdata, m_tuser);
			end else begin
				ans = decode_answers.pop_front();
				if (m_tdata !== {{(OUT_DATA_W-OUT_W){1'b0}}, ans.value} ||
					m_tuser !== ans.done) begin
					mismatches <= mismatches + 1;
					if (mismatches < MAX_REPORTS)
						$display("mismatch: value exp %0d got %0d, done exp %b got %b (tdata %h)",
							ans.value, m_tdata[OUT_W-1:0], ans.done, m_tuser, m_tdata);
				end
			end
			draw = snk_burst ? 0 : int'($urandom_range(0, 7));
			snk_wait <= draw;
			m_tready <= (draw == 0);
		end else if (snk_wait != 0) begin
			snk_wait <= snk_wait - 1;
			m_tready <= (snk_wait == 1);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// End the run when nothing moves on either side for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (arst_n && !(s_tvalid && s_tready) && !(m_tvalid && m_tready))
				quiet++;
			else
				quiet = 0;
		end
		$display("FAIL piecewise_decompand_table");
		$finish;
	end

	initial begin : stimulus
		int sorted [$];
		int mode;
		for (int r = 0; r < SEG_LIMITS; r++)
			lim_cfg[r] = LIMIT_RESET;
		offs_cfg = '0;
		for (int c = 0; c < CODE_COUNT; c++)
			decode_lut[c] = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration: everything in the first segment
		push_item(KIND_REBUILD, 8'hff);
		push_item(KIND_DECODE, 8'd0);
		push_item(KIND_DECODE, 8'd15);
		push_item(KIND_DECODE, 8'd14);
		push_item(KIND_DECODE, 8'd16);
		push_item(KIND_DECODE, 8'd255);
		push_item(KIND_DECODE, 8'd128);
		push_item(KIND_DECODE, 8'd127);
		push_item(KIND_REBUILD, 8'h00);
		push_item(KIND_DECODE, 8'd1);
		wait_idle();

		// All limits zero: every value falls in the fixed last segment, offsets all ones
		for (int r = 0; r < SEG_LIMITS; r++)
			next_lims[r] = '0;
		next_offs = '1;
		apply_config();
		push_item(KIND_REBUILD, 8'h5a);
		push_item(KIND_DECODE, 8'd0);
		push_item(KIND_DECODE, 8'd126);
		push_item(KIND_DECODE, 8'd127);
		push_item(KIND_DECODE, 8'd254);
		push_item(KIND_DECODE, 8'd255);
		wait_idle();

		// Limits past the input range, out of order
		next_lims[0] = LIMIT_W'(LIMIT_MAX);
		next_lims[1] = '0;
		next_lims[2] = LIMIT_RESET;
		next_lims[3] = LIMIT_W'(LIMIT_MAX);
		next_lims[4] = '0;
		next_offs = 40'h00_00_00_00_00;
		apply_config();
		push_item(KIND_REBUILD, 8'ha5);
		push_item(KIND_DECODE, 8'd15);
		push_item(KIND_DECODE, 8'd0);
		push_item(KIND_DECODE, 8'd255);
		wait_idle();

		for (int p = 0; p < RAND_PHASES; p++) begin
			mode = $urandom_range(0, 2);
			sorted.delete();
			for (int r = 0; r < SEG_LIMITS; r++) begin
				if (mode == 2)
					sorted.push_back($urandom_range(0, LIMIT_MAX));
				else if ($urandom_range(0, 7) == 0)
					sorted.push_back(int'(LIMIT_RESET));
				else
					sorted.push_back($urandom_range(0, VALUE_COUNT));
			end
			// ascending limits are the normal use; mode 2 keeps the random order
			if (mode != 2)
				sorted.sort();
			for (int r = 0; r < SEG_LIMITS; r++)
				next_lims[r] = LIMIT_W'(sorted[r]);
			next_offs = {8'($urandom), 32'($urandom)};
			src_burst = ($urandom_range(0, 3) == 0);
			snk_burst = ($urandom_range(0, 3) == 0);

			// New registers must not touch the table until the next rebuild
			wait_idle();
			apply_config();
			for (int i = 0; i < 25; i++)
				push_item(KIND_DECODE, 8'($urandom));
			push_item(KIND_REBUILD, 8'($urandom));
			for (int i = 0; i < 35; i++) begin
				if ($urandom_range(0, 39) == 0)
					push_item(KIND_REBUILD, 8'($urandom));
				else
					push_item(KIND_DECODE, 8'($urandom));
			end
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("PASS piecewise_decompand_table");
		else
			$display("FAIL piecewise_decompand_table");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/pwd_pkg.sv
hw/rtl/pwd_ctrl.sv
hw/rtl/pwd_dp.sv
hw/rtl/piecewise_decompand_table.sv
hw/rtl/pwd_checker.sv
sim/piecewise_decompand_table_tb.sv
